// ===== src/assert_macros.svh =====
// assertion macros included by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, inactive while reset is held
`define TCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define TCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/tcd_pkg.sv =====
// constants and types of the tile change detector
package tcd_pkg;

    localparam int unsigned TILE_W    = 10;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned MAX_TILES = 1024;
    localparam int unsigned ADDR_W    = $clog2(MAX_TILES);
    localparam int unsigned ENTRY_W   = PIX_W + 1;

    localparam int unsigned IN_DATA_W  = ((TILE_W + PIX_W + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((TILE_W + PIX_W + 7) / 8) * 8;

    localparam logic [PIX_W-1:0] SEED = 32'h0815_4711;
    localparam int unsigned MOD       = 211;
    localparam int unsigned RES_W     = $clog2(MOD);

    // residues of powers of two and of the seed modulo the checksum modulus
    localparam int unsigned W1 = 256 % MOD;
    localparam int unsigned W2 = 65536 % MOD;
    localparam int unsigned W3 = 16777216 % MOD;
    localparam logic [RES_W-1:0] WRAP_RES = RES_W'(64'h1_0000_0000 % 64'(MOD));
    localparam logic [RES_W-1:0] SEED_RES = RES_W'(SEED % PIX_W'(MOD));

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic              changed;
        logic [PIX_W-1:0]  checksum;
    } t_result;

endpackage

// ===== src/tile_change_detector_unit.sv =====
// tile change detector: per-pixel checksum, per-tile compare against a checksum store
// stages 1, 2, 3 and the output register lie between a tile's last pixel and result
// throughput: one pixel per cycle unless the skid register is full or clearing runs,
// set by the checksum loop and store read-compare-write (same-tile writes forwarded)
// reset: synchronous active low; then a clearing pass zeroes all 1024 store entries,
// during which o_s_axis_tready stays low
`include "assert_macros.svh"

module tile_change_detector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tile_index[9:0], pixel_value[41:10], zero pad
    input  logic [tcd_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // done_tile[9:0], tile_checksum[41:10], zero pad
    output logic [tcd_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // tile_changed[0]
    output logic                            o_m_axis_tuser
);

    function automatic logic [tcd_pkg::RES_W-1:0] reduce_small(input logic [9:0] v);
        logic [9:0] r;
        r = v;
        priority if (v >= 10'(3 * tcd_pkg::MOD)) r = v - 10'(3 * tcd_pkg::MOD);
        else if (v >= 10'(2 * tcd_pkg::MOD))     r = v - 10'(2 * tcd_pkg::MOD);
        else if (v >= 10'(tcd_pkg::MOD))         r = v - 10'(tcd_pkg::MOD);
        else                                     r = v;
        return r[tcd_pkg::RES_W-1:0];
    endfunction

    function automatic logic [16:0] byte_fold(input logic [tcd_pkg::PIX_W-1:0] p);
        logic [16:0] f;
        f = 17'(p[7:0])
          + 17'(p[15:8])  * 17'(tcd_pkg::W1)
          + 17'(p[23:16]) * 17'(tcd_pkg::W2)
          + 17'(p[31:24]) * 17'(tcd_pkg::W3);
        return f;
    endfunction

    function automatic logic [tcd_pkg::RES_W-1:0] fold_reduce(input logic [16:0] f);
        logic [13:0] g1;
        logic [11:0] g2;
        logic [9:0]  g3;
        g1 = 14'(f[16:8]) * 14'(tcd_pkg::W1) + 14'(f[7:0]);
        g2 = 12'(g1[13:8]) * 12'(tcd_pkg::W1) + 12'(g1[7:0]);
        g3 = 10'(g2[11:8]) * 10'(tcd_pkg::W1) + 10'(g2[7:0]);
        return reduce_small(g3);
    endfunction

    // pipeline enable
    logic w_en;

    // store clearing
    logic                       r_clearing;
    logic [tcd_pkg::ADDR_W-1:0] r_clr_addr;

    // stage 1
    logic                        r_s1_valid;
    logic                        r_s1_last;
    logic [tcd_pkg::TILE_W-1:0]  r_s1_tile;
    logic [tcd_pkg::PIX_W-1:0]   r_s1_pix;
    logic [16:0]                 r_s1_fold;

    // stage 2
    logic                        r_s2_valid;
    logic                        r_s2_last;
    logic [tcd_pkg::TILE_W-1:0]  r_s2_tile;
    logic [tcd_pkg::PIX_W-1:0]   r_s2_pix;
    logic [tcd_pkg::RES_W-1:0]   r_s2_pmod;

    // running checksum and its residue
    logic [tcd_pkg::PIX_W-1:0]   r_sum;
    logic [tcd_pkg::RES_W-1:0]   r_sum_mod;
    logic [tcd_pkg::PIX_W+1:0]   w_add;
    logic [9:0]                  w_wrap_res;
    logic [9:0]                  w_res_raw;
    logic [tcd_pkg::PIX_W-1:0]   n_sum;
    logic [tcd_pkg::RES_W-1:0]   n_sum_mod;

    // stage 3 (finished tiles)
    logic                        r_s3_valid;
    logic [tcd_pkg::TILE_W-1:0]  r_s3_tile;
    logic [tcd_pkg::PIX_W-1:0]   r_s3_sum;

    // checksum store
    logic [tcd_pkg::ENTRY_W-1:0] mem [tcd_pkg::MAX_TILES];
    logic [tcd_pkg::ENTRY_W-1:0] r_rd_data;
    logic                        r_fwd_hit;
    logic [tcd_pkg::PIX_W-1:0]   r_fwd_sum;
    logic                        n_fwd_hit;
    logic                        w_mem_we;
    logic [tcd_pkg::ADDR_W-1:0]  w_mem_waddr;
    logic [tcd_pkg::ENTRY_W-1:0] w_mem_wdata;
    logic [tcd_pkg::ENTRY_W-1:0] w_old;

    // result and output buffering
    tcd_pkg::t_result w_res;
    tcd_pkg::t_result r_out;
    tcd_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en && !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == tcd_pkg::ADDR_W'(tcd_pkg::MAX_TILES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // stage 1: byte fold of the pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_s_axis_tvalid && o_s_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_last <= i_s_axis_tlast;
            r_s1_tile <= i_s_axis_tdata[tcd_pkg::TILE_W-1:0];
            r_s1_pix  <= i_s_axis_tdata[tcd_pkg::TILE_W +: tcd_pkg::PIX_W];
            r_s1_fold <= byte_fold(i_s_axis_tdata[tcd_pkg::TILE_W +: tcd_pkg::PIX_W]);
        end
    end

    // stage 2: pixel residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_last <= r_s1_last;
            r_s2_tile <= r_s1_tile;
            r_s2_pix  <= r_s1_pix;
            r_s2_pmod <= fold_reduce(r_s1_fold);
        end
    end

    // checksum loop, residue tracked alongside the sum
    always_comb begin
        w_add     = (tcd_pkg::PIX_W + 2)'(r_sum) + (tcd_pkg::PIX_W + 2)'(r_sum_mod)
                  + (tcd_pkg::PIX_W + 2)'(r_s2_pix);
        // one or two wraps past 32 bits
        priority if (w_add[tcd_pkg::PIX_W + 1]) begin
            w_wrap_res = 10'((2 * (tcd_pkg::MOD - tcd_pkg::WRAP_RES)) % tcd_pkg::MOD);
        end else if (w_add[tcd_pkg::PIX_W]) begin
            w_wrap_res = 10'(tcd_pkg::MOD - tcd_pkg::WRAP_RES);
        end else begin
            w_wrap_res = 10'd0;
        end
        w_res_raw = 10'(r_sum_mod) + 10'(r_sum_mod) + 10'(r_s2_pmod) + w_wrap_res;
        n_sum     = w_add[tcd_pkg::PIX_W-1:0];
        n_sum_mod = reduce_small(w_res_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= tcd_pkg::SEED;
            r_sum_mod <= tcd_pkg::SEED_RES;
        end else if (w_en && r_s2_valid) begin
            if (r_s2_last) begin
                r_sum     <= tcd_pkg::SEED;
                r_sum_mod <= tcd_pkg::SEED_RES;
            end else begin
                r_sum     <= n_sum;
                r_sum_mod <= n_sum_mod;
            end
        end
    end

    // stage 3: finished tile, store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid && r_s2_last;
        end
    end

    assign n_fwd_hit = r_s3_valid && r_s2_valid && r_s2_last && (r_s3_tile == r_s2_tile);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_tile <= r_s2_tile;
            r_s3_sum  <= n_sum;
            r_fwd_hit <= n_fwd_hit;
            r_fwd_sum <= r_s3_sum;
        end
    end

    // store write port: clearing pass or tile update
    always_comb begin
        w_mem_we    = r_clearing || (w_en && r_s3_valid);
        w_mem_waddr = r_clearing ? r_clr_addr : r_s3_tile[tcd_pkg::ADDR_W-1:0];
        w_mem_wdata = r_clearing ? '0 : {1'b1, r_s3_sum};
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_en) begin
            r_rd_data <= mem[r_s2_tile[tcd_pkg::ADDR_W-1:0]];
        end
    end

    // compare against the stored entry, newest write forwarded
    always_comb begin
        w_old            = r_fwd_hit ? {1'b1, r_fwd_sum} : r_rd_data;
        w_res.tile       = r_s3_tile;
        w_res.checksum   = r_s3_sum;
        w_res.changed    = !w_old[tcd_pkg::PIX_W] || (w_old[tcd_pkg::PIX_W-1:0] != r_s3_sum);
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !i_m_axis_tready) begin
            r_skid_valid <= r_s3_valid;
        end else begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (r_out_valid && !i_m_axis_tready) begin
            r_skid <= w_res;
        end else begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = tcd_pkg::OUT_DATA_W'({r_out.checksum, r_out.tile});
    assign o_m_axis_tuser  = r_out.changed;

    `TCD_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid without output")
    `TCD_ASSERT(a_no_accept_clearing, r_clearing |-> !o_s_axis_tready, "accept while clearing")
    `TCD_ASSERT(a_stall_sum, !w_en |=> $stable(r_sum) && $stable(r_sum_mod), "stall moved sum")
    `TCD_ASSERT(a_fwd_needs_tile, r_fwd_hit |-> r_s3_valid, "forward without tile")

endmodule

// ===== sim/tile_change_detector_unit_test.sv =====
// testbench for the tile change detector unit
module tile_change_detector_unit_test;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS = 10;
    localparam int POOL_SIZE = 8;
    localparam int MAX_TILE_LEN = 32;
    localparam int PHASE_PIXELS = 570;

    typedef struct packed {
        logic [tcd_pkg::TILE_W-1:0] tile;
        logic [tcd_pkg::PIX_W-1:0]  pixel;
        logic                       last;
        logic                       typed;
        logic                       changed;
        logic [tcd_pkg::PIX_W-1:0]  checksum;
    } t_pixel_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic [tcd_pkg::IN_DATA_W-1:0]  s_data = '0;
    logic                           s_last = 1'b0;
    logic                           m_ready = 1'b0;
    logic                           o_s_axis_tready;
    logic                           o_m_axis_tvalid;
    logic [tcd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tuser;

    // checksum predictor state
    logic [tcd_pkg::PIX_W-1:0] run_sum = tcd_pkg::SEED;
    logic [tcd_pkg::PIX_W-1:0] stored_sum [tcd_pkg::MAX_TILES];
    bit                        tile_seen [tcd_pkg::MAX_TILES];

    tcd_pkg::t_result expected_tiles [$];
    t_pixel_row       directed_rows [$];
    t_pixel_row       cur_row = '0;
    int               mismatches = 0;
    int               cycles = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    logic [tcd_pkg::TILE_W-1:0] pool_tile [POOL_SIZE];
    logic [tcd_pkg::PIX_W-1:0]  pool_pix [POOL_SIZE][MAX_TILE_LEN];
    int                         pool_len [POOL_SIZE];

    always #HALF_PERIOD i_clk = ~i_clk;

    tile_change_detector_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    function automatic bit absorb_pixel(input logic [tcd_pkg::TILE_W-1:0] tile,
                                        input logic [tcd_pkg::PIX_W-1:0] pix,
                                        input logic last,
                                        output tcd_pkg::t_result res);
        logic [tcd_pkg::PIX_W-1:0] total;
        res = '0;
        run_sum = run_sum + (run_sum % tcd_pkg::PIX_W'(tcd_pkg::MOD)) + pix;
        if (!last) return 1'b0;
        total = run_sum;
        run_sum = tcd_pkg::SEED;
        res.tile = tile;
        res.checksum = total;
        if (tile < tcd_pkg::MAX_TILES) begin
            res.changed = !tile_seen[tile] || stored_sum[tile] != total;
            stored_sum[tile] = total;
            tile_seen[tile] = 1'b1;
        end else begin
            res.changed = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input tcd_pkg::t_result want,
                                 input tcd_pkg::t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected tile %0d chg %0b sum %h, got tile %0d chg %0b sum %h",
                     what, want.tile, want.changed, want.checksum,
                     got.tile, got.changed, got.checksum);
    endtask

    always @(negedge i_clk)
        m_ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL tile_change_detector_unit");
            $finish;
        end
    end

    always @(posedge i_clk) begin : monitor
        tcd_pkg::t_result pred;
        tcd_pkg::t_result got;
        tcd_pkg::t_result want;
        if (i_rst_n && s_valid && o_s_axis_tready) begin
            if (absorb_pixel(s_data[tcd_pkg::TILE_W-1:0],
                             s_data[tcd_pkg::TILE_W +: tcd_pkg::PIX_W], s_last, pred)) begin
                if (cur_row.typed) begin
                    pred.changed = cur_row.changed;
                    pred.checksum = cur_row.checksum;
                end
                expected_tiles.push_back(pred);
            end
        end
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got.tile = o_m_axis_tdata[tcd_pkg::TILE_W-1:0];
            got.changed = o_m_axis_tuser;
            got.checksum = o_m_axis_tdata[tcd_pkg::TILE_W +: tcd_pkg::PIX_W];
            if (expected_tiles.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_tiles.pop_front();
                if (got.tile !== want.tile || got.changed !== want.changed ||
                    got.checksum !== want.checksum)
                    note_mismatch("mismatch", want, got);
            end
        end
    end

    // holds the pixel until its transaction completes, returns at the falling edge
    task automatic send_pixel(input t_pixel_row row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        cur_row = row;
        s_data = tcd_pkg::IN_DATA_W'({row.pixel, row.tile});
        s_last = row.last;
        s_valid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [tcd_pkg::PIX_W-1:0] rand_pixel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        return $urandom;
    endfunction

    task automatic send_tile(input logic [tcd_pkg::TILE_W-1:0] tile, input int len,
                             input logic [tcd_pkg::PIX_W-1:0] pix [MAX_TILE_LEN]);
        t_pixel_row row;
        for (int i = 0; i < len; i++) begin
            row = '0;
            row.pixel = pix[i];
            row.last = (i == len - 1);
            row.tile = tile;
            if (!row.last && $urandom_range(9) == 0)
                row.tile = tcd_pkg::TILE_W'($urandom_range(tcd_pkg::MAX_TILES - 1));
            send_pixel(row);
        end
    endtask

    task automatic run_random(input int pixels, input int send_pct, input int recv_pct);
        logic [tcd_pkg::PIX_W-1:0]  pix [MAX_TILE_LEN];
        logic [tcd_pkg::TILE_W-1:0] tile;
        int sent;
        int len;
        int slot;
        int choice;
        int spot;
        sent = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < pixels) begin
            slot = $urandom_range(POOL_SIZE - 1);
            choice = $urandom_range(99);
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) :
                  $urandom_range(7, MAX_TILE_LEN);
            if (choice < 35 && pool_len[slot] != 0) begin
                // revisit with the same content, sometimes with one bit flipped
                tile = pool_tile[slot];
                len = pool_len[slot];
                pix = pool_pix[slot];
                if ($urandom_range(3) == 0) begin
                    spot = $urandom_range(len - 1);
                    pix[spot][$urandom_range(tcd_pkg::PIX_W - 1)] ^= 1'b1;
                    pool_pix[slot] = pix;
                end
            end else begin
                for (int i = 0; i < MAX_TILE_LEN; i++) pix[i] = rand_pixel();
                if (choice < 60) begin
                    tile = pool_tile[slot];
                    pool_pix[slot] = pix;
                    pool_len[slot] = len;
                end else begin
                    tile = tcd_pkg::TILE_W'($urandom_range(tcd_pkg::MAX_TILES - 1));
                end
            end
            send_tile(tile, len, pix);
            sent += len;
        end
    endtask

    initial begin
        for (int s = 0; s < POOL_SIZE; s++) begin
            pool_tile[s] = tcd_pkg::TILE_W'($urandom_range(tcd_pkg::MAX_TILES - 1));
            pool_len[s] = 0;
        end
        pool_tile[0] = '0;
        pool_tile[1] = tcd_pkg::TILE_W'(tcd_pkg::MAX_TILES - 1);

        // single-pixel tiles at the extremes, then repeats and changes
        directed_rows.push_back('{10'd0,    32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0815_47AD});
        directed_rows.push_back('{10'd0,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0815_47AD});
        directed_rows.push_back('{10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h0815_47AC});
        directed_rows.push_back('{10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0815_47AC});
        directed_rows.push_back('{10'd1023, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0815_47AD});
        for (int r = 0; r < 2; r++) begin
            directed_rows.push_back('{10'd5, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 32'h0});
            directed_rows.push_back('{10'd5, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0});
            directed_rows.push_back('{10'd5, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0});
            directed_rows.push_back('{10'd5, 32'hA5A5_A5A5, 1'b1, 1'b0, 1'b0, 32'h0});
        end
        // mixed indices inside one tile
        directed_rows.push_back('{10'd7,    32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd9,    32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd5,    32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd512,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd512,  32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd0,    32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd0,    32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd682,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0});
        directed_rows.push_back('{10'd341,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 80;
        foreach (directed_rows[r]) send_pixel(directed_rows[r]);

        run_random(PHASE_PIXELS, 7, 80);
        run_random(PHASE_PIXELS, 80, 7);
        run_random(PHASE_PIXELS, 0, 0);
        s_valid = 1'b0;

        while (expected_tiles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_tiles.size() == 0)
            $display("PASS tile_change_detector_unit");
        else
            $display("FAIL tile_change_detector_unit");
        $finish;
    end

endmodule
